@@ rtl/siphash_2_4_keyed_hash_defines.svh @@
// Assertion helpers for the top-level RTL.
`ifndef SIPHASH_2_4_KEYED_HASH_DEFINES_SVH
`define SIPHASH_2_4_KEYED_HASH_DEFINES_SVH

`ifndef SYNTHESIS
// ante holds -> cons holds in the same cycle
`define SH24_ASSERT_SAME(label, clk_, rst_, ante, cons) \
  label: assert property (@(posedge clk_) disable iff (rst_) (ante) |-> (cons)) \
    else $error("sh24 same-cycle check failed");
// ante holds -> cons holds in the next cycle
`define SH24_ASSERT_NEXT(label, clk_, rst_, ante, cons) \
  label: assert property (@(posedge clk_) disable iff (rst_) (ante) |=> (cons)) \
    else $error("sh24 next-cycle check failed");
`else
`define SH24_ASSERT_SAME(label, clk_, rst_, ante, cons)
`define SH24_ASSERT_NEXT(label, clk_, rst_, ante, cons)
`endif

`endif

@@ rtl/sh24_pkg.sv @@
package sh24_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] FIN_FLIP = 64'h00000000000000ff;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lanes_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // input transfer: latch word, update length
    logic start;      // first word of a message: lanes from key
    logic round;      // run one SipRound on the lanes
    logic xor_d;      // d ^= m before the round
    logic xor_a;      // a ^= m after the round
    logic xor_c;      // c ^= 0xff before the round
    logic load_tail;  // m <= length byte only (empty tail)
    logic out_load;   // capture digest
  } sh24_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;       // word is compressed as a full 8-byte word
  } sh24_stat_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

  function automatic lanes_t sip_round(input lanes_t v);
    lanes_t o;
    o = v;
    o.a = o.a + o.b;
    o.b = rotl(o.b, 13) ^ o.a;
    o.a = rotl(o.a, 32);
    o.c = o.c + o.d;
    o.d = rotl(o.d, 16) ^ o.c;
    o.a = o.a + o.d;
    o.d = rotl(o.d, 21) ^ o.a;
    o.c = o.c + o.b;
    o.b = rotl(o.b, 17) ^ o.c;
    o.c = rotl(o.c, 32);
    sip_round = o;
  endfunction

  // keep the low n bytes of a tail word
  function automatic logic [63:0] tail_mask(input logic [2:0] n);
    logic [63:0] m;
    case (n)
      3'd0:    m = 64'h0000000000000000;
      3'd1:    m = 64'h00000000000000ff;
      3'd2:    m = 64'h000000000000ffff;
      3'd3:    m = 64'h0000000000ffffff;
      3'd4:    m = 64'h00000000ffffffff;
      3'd5:    m = 64'h000000ffffffffff;
      3'd6:    m = 64'h0000ffffffffffff;
      3'd7:    m = 64'h00ffffffffffffff;
      default: m = 64'h0000000000000000;
    endcase
    tail_mask = m;
  endfunction

endpackage

@@ rtl/sh24_datapath.sv @@
module sh24_datapath
  import sh24_pkg::*;
(
  input  logic        clk,
  input  logic [63:0] data_word,
  input  logic [3:0]  valid_bytes,
  input  logic        last,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  sh24_cmd_t   cmd,
  output sh24_stat_t  stat,
  output logic [63:0] digest
);

  lanes_t      lanes;
  lanes_t      round_in;
  lanes_t      round_out;
  lanes_t      lanes_init;
  logic [63:0] m;
  logic [7:0]  length;
  logic [7:0]  length_next;
  logic [3:0]  byte_add;
  logic [63:0] word_m;

  // count of eight or more, or any word that is not last, is a full word
  assign stat.full = !last || valid_bytes[3];
  assign byte_add  = stat.full ? 4'd8 : {1'b0, valid_bytes[2:0]};
  assign length_next = (cmd.start ? 8'd0 : length) + {4'd0, byte_add};

  assign word_m = stat.full ? data_word
                            : ((data_word & tail_mask(valid_bytes[2:0]))
                               | {length_next, 56'd0});

  assign lanes_init.a = SIP_C0 ^ key_low;
  assign lanes_init.b = SIP_C1 ^ key_high;
  assign lanes_init.c = SIP_C2 ^ key_low;
  assign lanes_init.d = SIP_C3 ^ key_high;

  always_comb begin
    round_in = lanes;
    if (cmd.xor_d) begin
      round_in.d = lanes.d ^ m;
    end
    if (cmd.xor_c) begin
      round_in.c = lanes.c ^ FIN_FLIP;
    end
    round_out = sip_round(round_in);
    if (cmd.xor_a) begin
      round_out.a = round_out.a ^ m;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && cmd.start) begin
      lanes <= lanes_init;
    end else if (cmd.round) begin
      lanes <= round_out;
    end
    if (cmd.load) begin
      m      <= word_m;
      length <= length_next;
    end else if (cmd.load_tail) begin
      m <= {length, 56'd0};
    end
    if (cmd.out_load) begin
      digest <= round_out.a ^ round_out.b ^ round_out.c ^ round_out.d;
    end
  end

endmodule

@@ rtl/sh24_ctrl.sv @@
module sh24_ctrl
  import sh24_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tlast,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  sh24_stat_t stat,
  output sh24_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_R1   = 2'd1;
  localparam logic [1:0] ST_R2   = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state, state_next;
  logic       in_message, in_message_next;
  logic       tail_pend, tail_pend_next;
  logic       fin_pend, fin_pend_next;
  logic [1:0] fin_cnt, fin_cnt_next;
  logic       out_valid, out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;

  always_comb begin
    state_next      = state;
    in_message_next = in_message;
    tail_pend_next  = tail_pend;
    fin_pend_next   = fin_pend;
    fin_cnt_next    = fin_cnt;
    s_tready        = 1'b0;
    cmd             = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load        = 1'b1;
          cmd.start       = !in_message;
          in_message_next = 1'b1;
          tail_pend_next  = s_tlast && stat.full;
          fin_pend_next   = s_tlast;
          state_next      = ST_R1;
        end
      end
      ST_R1: begin
        cmd.round  = 1'b1;
        cmd.xor_d  = 1'b1;
        state_next = ST_R2;
      end
      ST_R2: begin
        cmd.round = 1'b1;
        cmd.xor_a = 1'b1;
        if (tail_pend) begin
          cmd.load_tail  = 1'b1;
          tail_pend_next = 1'b0;
          state_next     = ST_R1;
        end else if (fin_pend) begin
          fin_cnt_next = 2'd0;
          state_next   = ST_FIN;
        end else begin
          // mid-message: next word overlaps the closing round
          s_tready = 1'b1;
          if (s_tvalid) begin
            cmd.load       = 1'b1;
            tail_pend_next = s_tlast && stat.full;
            fin_pend_next  = s_tlast;
            state_next     = ST_R1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (fin_cnt != 2'd3 || out_free) begin
          cmd.round    = 1'b1;
          cmd.xor_c    = (fin_cnt == 2'd0);
          fin_cnt_next = fin_cnt + 2'd1;
          if (fin_cnt == 2'd3) begin
            cmd.out_load    = 1'b1;
            in_message_next = 1'b0;
            fin_pend_next   = 1'b0;
            state_next      = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_message <= 1'b0;
      tail_pend  <= 1'b0;
      fin_pend   <= 1'b0;
      fin_cnt    <= 2'd0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      in_message <= in_message_next;
      tail_pend  <= tail_pend_next;
      fin_pend   <= fin_pend_next;
      fin_cnt    <= fin_cnt_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

@@ rtl/siphash_2_4_keyed_hash.sv @@
// SipHash-2-4: one SipRound per cycle, shared round unit, except when idle or FIN awaits output.
// Each full message word runs R1 then R2; the closing round overlaps the next word's transfer.
// Last-word transfer to digest valid: R1, R2 (again for the empty tail with 8+ bytes), then FIN.
// A new message is taken the cycle after the digest is loaded; output register decouples m_axis.
// Reset (rst, synchronous): controller idle, no message open, output empty; key registers zero.
`include "siphash_2_4_keyed_hash_defines.svh"

module siphash_2_4_keyed_hash
  import sh24_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // message words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [63:0] data_word, [67:64] valid_bytes, [71:68] zero
  input  logic        s_axis_tlast,   // last
  // digest
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] digest
  // key registers: 0x0 key_low, 0x8 key_high
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] key_low;
  logic [63:0] key_high;
  logic        cfg_write;
  sh24_cmd_t   cmd;
  sh24_stat_t  stat;

  // --- configuration -------------------------------------------------------
  // Key is sampled only at message start, so a write mid-message takes
  // effect on the next message.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[3] ? key_high : key_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= 64'd0;
      key_high <= 64'd0;
    end else if (cfg_write) begin
      if (paddr[3]) begin
        key_high <= pwdata;
      end else begin
        key_low <= pwdata;
      end
    end
  end

  // --- sequencer -----------------------------------------------------------
  // IDLE takes a word, as does R2 mid-message; R1/R2 are the two compression
  // rounds; a last word of 8+ bytes loops R1/R2 again for the empty tail; FIN
  // runs the four finalization rounds, holding on the last while output is full.
  sh24_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tlast  (s_axis_tlast),
    .s_tready (s_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // --- lanes, message word, length byte, digest register -------------------
  sh24_datapath u_datapath (
    .clk         (clk),
    .data_word   (s_axis_tdata[63:0]),
    .valid_bytes (s_axis_tdata[67:64]),
    .last        (s_axis_tlast),
    .key_low     (key_low),
    .key_high    (key_high),
    .cmd         (cmd),
    .stat        (stat),
    .digest      (m_axis_tdata)
  );

  // --- checks --------------------------------------------------------------
  // digest is never overwritten while the previous one still waits
  `SH24_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.out_load, !(m_axis_tvalid && !m_axis_tready))
  // a loaded digest is presented on the next cycle
  `SH24_ASSERT_NEXT(a_out_shows, clk, rst, cmd.out_load, m_axis_tvalid)
  // no input transfer while finishing or queuing the empty tail
  `SH24_ASSERT_SAME(a_busy_no_take, clk, rst, cmd.out_load || cmd.load_tail, !s_axis_tready)

endmodule

@@ verif/tb_siphash_2_4_keyed_hash.sv @@
`timescale 1ns / 1ps

// Scoreboard: keyed SipHash-2-4 predictor plus a queue of expected digests.
class digest_scoreboard;
  localparam logic [63:0] INIT_A = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_B = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_C = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_D = 64'h7465646279746573;

  logic [63:0] k0 = '0;
  logic [63:0] k1 = '0;
  logic [63:0] va = '0;
  logic [63:0] vb = '0;
  logic [63:0] vc = '0;
  logic [63:0] vd = '0;
  logic [7:0]  msg_len = '0;
  bit          open_msg = 1'b0;
  logic [63:0] digest_q[$];
  int          errors = 0;
  int          checked = 0;

  // keys are latched by the block at the next message start
  function void set_keys(logic [63:0] lo, logic [63:0] hi);
    k0 = lo;
    k1 = hi;
  endfunction

  function logic [63:0] rol(logic [63:0] x, int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function void mix_round();
    va = va + vb;
    vb = rol(vb, 13) ^ va;
    va = rol(va, 32);
    vc = vc + vd;
    vd = rol(vd, 16) ^ vc;
    va = va + vd;
    vd = rol(vd, 21) ^ va;
    vc = vc + vb;
    vb = rol(vb, 17) ^ vc;
    vc = rol(vc, 32);
  endfunction

  function void absorb(logic [63:0] m);
    vd = vd ^ m;
    mix_round();
    mix_round();
    va = va ^ m;
  endfunction

  // one accepted message word
  function void note_word(logic [63:0] w, logic [3:0] cnt, logic fin);
    int unsigned n;
    logic [63:0] tail;
    if (!open_msg) begin
      va = INIT_A ^ k0;
      vb = INIT_B ^ k1;
      vc = INIT_C ^ k0;
      vd = INIT_D ^ k1;
      msg_len = '0;
      open_msg = 1'b1;
    end
    n = cnt;
    // non-last words and counts above eight are full words
    if (n > 8 || !fin) n = 8;
    if (n == 8) begin
      absorb(w);
      msg_len = msg_len + 8'd8;
      if (!fin) return;
      tail = '0;
    end else begin
      tail = w & ((64'd1 << (8 * n)) - 64'd1);
      msg_len = msg_len + 8'(n);
    end
    tail[63:56] = msg_len;
    absorb(tail);
    vc = vc ^ 64'hff;
    repeat (4) mix_round();
    digest_q.push_back(va ^ vb ^ vc ^ vd);
    open_msg = 1'b0;
  endfunction

  function void check_digest(logic [63:0] got);
    logic [63:0] want;
    if (digest_q.size() == 0) begin
      $error("unexpected digest transfer: digest %h", got);
      errors++;
      return;
    end
    want = digest_q.pop_front();
    checked++;
    if (got !== want) begin
      $error("field digest mismatch: expected %h, actual %h", want, got);
      errors++;
    end
  endfunction

  function int pending();
    return digest_q.size();
  endfunction
endclass

module tb_siphash_2_4_keyed_hash;
  localparam logic [3:0] KEY_LOW_ADDR  = 4'h0;
  localparam logic [3:0] KEY_HIGH_ADDR = 4'h8;
  localparam int HOLD_CYCLES = 400;   // long receiver back-pressure stretch
  localparam int QUIET_LIMIT = 5000;  // cycles with no transfer before giving up
  localparam int SETTLE      = 12;    // settle margin after the last digest
  localparam int PHASE_WORDS = 430;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;     // [63:0] data_word, [67:64] valid_bytes, [71:68] zero
  logic        s_axis_tlast = 1'b0;   // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;          // [63:0] digest
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  digest_scoreboard sb;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int words_sent = 0;
  int msgs_sent = 0;
  int quiet = 0;

  siphash_2_4_keyed_hash dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk = ~clk;

  // Digest receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: feeds the predictor on input transfers, checks output transfers,
  // and runs the watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_word(s_axis_tdata[63:0], s_axis_tdata[67:64], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_digest(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d digests outstanding",
                 QUIET_LIMIT, sb.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One word; returns right after the edge where it was accepted.
  task automatic send_word(input logic [63:0] w, input logic [3:0] n, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, n, w};
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
    if (fin) msgs_sent++;
  endtask

  // Stop offering, wait for every digest, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Back-to-back APB writes of both key halves; block must be idle.
  task automatic set_keys(input logic [63:0] lo, input logic [63:0] hi);
    for (int i = 0; i < 2; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= (i == 0) ? KEY_LOW_ADDR : KEY_HIGH_ADDR;
      pwdata  <= (i == 0) ? lo : hi;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_keys(lo, hi);
  endtask

  // Mostly short messages, some long enough to wrap the length byte.
  task automatic send_message();
    int r;
    int nw;
    logic [3:0] cnt;
    r = $urandom_range(99);
    if (r < 70)      nw = $urandom_range(1, 3);
    else if (r < 95) nw = $urandom_range(4, 10);
    else             nw = $urandom_range(30, 40);
    for (int i = 0; i < nw; i++) begin
      if (i == nw - 1)
        cnt = ($urandom_range(99) < 85) ? 4'($urandom_range(8)) : 4'($urandom_range(9, 15));
      else
        // short counts on inner words are ignored by the block
        cnt = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8;
      send_word(rand_word(), cnt, i == nw - 1);
    end
  endtask

  task automatic random_phase(input int nwords);
    int first;
    first = words_sent;
    while (words_sent - first < nwords) send_message();
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, keys still at their reset value of zero.
    tx_idle_pct = 14;
    rx_idle_pct = 80;
    send_word(rand_word(), 4'd0, 1'b1);          // empty message, junk above count
    send_word('1, 4'd7, 1'b1);
    send_word('1, 4'd8, 1'b1);                   // eight-byte last word: extra empty tail
    send_word(rand_word(), 4'd15, 1'b1);         // counts above eight act as eight
    send_word(rand_word(), 4'd9, 1'b1);
    send_word('0, 4'd3, 1'b0);                   // short inner word is a full word
    send_word(rand_word(), 4'd5, 1'b1);
    send_word('0, 4'd0, 1'b0);
    send_word('1, 4'd4, 1'b1);
    send_word(rand_word(), 4'd8, 1'b0);
    send_word(rand_word(), 4'd8, 1'b0);
    send_word(rand_word(), 4'd1, 1'b1);
    for (int n = 1; n <= 6; n++) send_word(rand_word(), 4'(n), 1'b1);
    for (int n = 10; n <= 14; n++) send_word(rand_word(), 4'(n), 1'b1);
    drain();

    // sender idles a little, receiver a lot
    set_keys('1, '1);
    random_phase(PHASE_WORDS);
    drain();

    // receiver idles a little, sender a lot
    tx_idle_pct = 80;
    rx_idle_pct = 14;
    set_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    random_phase(PHASE_WORDS);
    drain();

    // no idling; long receiver hold-off so the block backs up into its input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_keys({$urandom, $urandom}, {$urandom, $urandom});
    hold_req = 1'b1;
    random_phase(PHASE_WORDS);
    drain();

    set_keys('0, '1);
    random_phase(PHASE_WORDS);
    drain();

    $display("run covered %0d words in %0d messages under 5 key settings", words_sent,
             msgs_sent);
    $display("%0d digests checked, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/sh24_pkg.sv
rtl/sh24_datapath.sv
rtl/sh24_ctrl.sv
rtl/siphash_2_4_keyed_hash.sv
verif/tb_siphash_2_4_keyed_hash.sv
